// File: rtl/core/srtf_pkg.sv
// Shared types and constants for the SRTF tick scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int FIELD_W       = 16;
  localparam int SLOT_W        = 4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Best candidate seen so far, handed from cell to cell along the chain.
  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] remaining;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } token_t;

endpackage

// File: rtl/core/srtf_cell.sv
// One task slot of the scheduler chain with its compare stage.
`timescale 1ns / 1ps

module srtf_cell #(
  parameter int INDEX     = 0,
  parameter int TIME_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_en,
  input  logic [srtf_pkg::SLOT_W-1:0]  load_slot,
  input  logic [srtf_pkg::FIELD_W-1:0] load_arrival,
  input  logic [srtf_pkg::FIELD_W-1:0] load_burst,
  input  logic                         run_en,
  input  logic [TIME_BITS-1:0]         time_cur,
  input  srtf_pkg::token_t             tok_in,
  input  logic [IDX_W-1:0]             pick_in,
  output srtf_pkg::token_t             tok_out,
  output logic [IDX_W-1:0]             pick_out,
  output logic                         pending
);
  import srtf_pkg::*;

  localparam int CMP_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  logic [FIELD_W-1:0] arrival;
  logic [FIELD_W-1:0] burst;
  logic [FIELD_W-1:0] remaining;
  logic [FIELD_W-1:0] remaining_next;
  logic               valid;
  logic               done;
  logic               hit;
  logic               eligible;
  logic               take;

  assign hit = load_en && (32'(load_slot) == INDEX);
  assign eligible = valid && !done && (CMP_W'(arrival) <= CMP_W'(time_cur));
  // Strict less-than keeps the earlier (lower) slot on a tie.
  assign take = eligible && (!tok_in.found || (remaining < tok_in.remaining));
  assign remaining_next = (remaining == '0) ? remaining : remaining - 1'b1;
  assign pending = valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      done  <= 1'b0;
    end else if (hit) begin
      valid <= 1'b1;
      done  <= (load_burst == '0);
    end else if (run_en) begin
      done <= (remaining_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      arrival   <= load_arrival;
      burst     <= load_burst;
      remaining <= load_burst;
    end else if (run_en) begin
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out.found     <= 1'b1;
      tok_out.remaining <= remaining;
      tok_out.arrival   <= arrival;
      tok_out.burst     <= burst;
      pick_out          <= IDX_W'(INDEX);
    end else begin
      tok_out  <= tok_in;
      pick_out <= pick_in;
    end
  end

endmodule

// File: rtl/core/srtf_tick_scheduler_unit.sv
// Top level of the shortest-remaining-time-first tick scheduler.
`timescale 1ns / 1ps

// Every item gives exactly one result, shown for one cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle. A load
// item's result appears in the cycle right after acceptance. For a tick item,
// the best candidate travels down the row of slot cells, one cell per
// cycle; then the apply state runs the picked task and advances time, and
// the calc state forms the waiting time. busy stays high until the result
// cycle is over, so the next item is accepted in the cycle after it at the
// earliest.
module srtf_tick_scheduler_unit #(
  parameter int MAX_TASKS = srtf_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = srtf_pkg::DEF_TIME_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [srtf_pkg::SLOT_W-1:0]  slot,
  input  logic [srtf_pkg::FIELD_W-1:0] arrival,
  input  logic [srtf_pkg::FIELD_W-1:0] burst,
  output logic                         done,
  output logic [srtf_pkg::SLOT_W-1:0]  ran_slot,
  output logic                         idle,
  output logic [srtf_pkg::FIELD_W-1:0] time_now,
  output logic                         finished,
  output logic [srtf_pkg::FIELD_W-1:0] finish_time,
  output logic [srtf_pkg::FIELD_W-1:0] turnaround,
  output logic [srtf_pkg::FIELD_W-1:0] waiting,
  output logic                         all_done,
  output logic                         time_overflow
);
  import srtf_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMP_W = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_APPLY  = 5'b00100,
    S_CALC   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] current_time;
  logic [TIME_BITS-1:0] time_next;
  logic                 time_sat;
  logic                 accept;
  logic                 load_en;
  logic                 fin_now;
  logic [CMP_W-1:0]     tat;
  logic [FIELD_W-1:0]   burst_hold;

  token_t           tok  [0:MAX_TASKS];
  logic [IDX_W-1:0] pick [0:MAX_TASKS];
  logic [MAX_TASKS-1:0] pending;
  logic [MAX_TASKS-1:0] run_en;

  assign accept  = start && !busy;
  assign load_en = accept && (kind == KIND_LOAD);
  assign busy    = (state != S_IDLE);
  assign done    = (state == S_REPORT);

  assign tok[0]  = '0;
  assign pick[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      assign run_en[gi] = (state == S_APPLY) && tok[MAX_TASKS].found &&
                          (pick[MAX_TASKS] == IDX_W'(gi));
      srtf_cell #(
        .INDEX     (gi),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .load_en      (load_en),
        .load_slot    (slot),
        .load_arrival (arrival),
        .load_burst   (burst),
        .run_en       (run_en[gi]),
        .time_cur     (current_time),
        .tok_in       (tok[gi]),
        .pick_in      (pick[gi]),
        .tok_out      (tok[gi+1]),
        .pick_out     (pick[gi+1]),
        .pending      (pending[gi])
      );
    end
  endgenerate

  assign all_done      = ~|pending;
  assign time_overflow = time_sat;
  assign time_now      = FIELD_W'(current_time);

  // Time holds at its maximum once reached.
  assign time_next = (current_time == '1) ? current_time : current_time + 1'b1;
  assign fin_now   = tok[MAX_TASKS].found && (tok[MAX_TASKS].remaining <= FIELD_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_TICK) ? S_SCAN : S_REPORT;
        end
      end
      S_SCAN: begin
        if (cnt == CNT_W'(MAX_TASKS - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY:  state_next = S_CALC;
      S_CALC:   state_next = S_REPORT;
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      current_time <= '0;
      time_sat     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (state == S_APPLY) begin
        current_time <= time_next;
        if (current_time == '1) begin
          time_sat <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      ran_slot    <= '0;
      idle        <= 1'b0;
      finished    <= 1'b0;
      finish_time <= '0;
      turnaround  <= '0;
      waiting     <= '0;
    end
    if (state == S_APPLY) begin
      ran_slot <= tok[MAX_TASKS].found ? SLOT_W'(pick[MAX_TASKS]) : '0;
      idle     <= !tok[MAX_TASKS].found;
      finished <= fin_now;
      if (fin_now) begin
        finish_time <= FIELD_W'(time_next);
        tat <= (CMP_W'(time_next) >= CMP_W'(tok[MAX_TASKS].arrival)) ?
               CMP_W'(time_next) - CMP_W'(tok[MAX_TASKS].arrival) : '0;
        burst_hold <= tok[MAX_TASKS].burst;
      end else begin
        finish_time <= '0;
        tat         <= '0;
        burst_hold  <= '0;
      end
    end
    if (state == S_CALC) begin
      turnaround <= FIELD_W'(tat);
      waiting    <= (tat >= CMP_W'(burst_hold)) ? FIELD_W'(tat - CMP_W'(burst_hold)) : '0;
    end
  end

endmodule
